### rtl/binary_patch_applier_core_macros.svh
// assertion macros shared by the patch applier rtl
`ifndef BINARY_PATCH_APPLIER_CORE_MACROS_SVH
`define BINARY_PATCH_APPLIER_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define BPA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define BPA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/bpa_pkg.sv
// types, constants and codes of the binary patch applier
package bpa_pkg;

  // patch header length in bytes
  localparam int unsigned HEADER_BYTES = 8;
  localparam logic [3:0] HEADER_INIT = 4'(HEADER_BYTES);

  // classified item queue depth
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OLD_LENGTH = 3'd0,
    REG_OP_COPY    = 3'd1,
    REG_OP_REPLACE = 3'd2,
    REG_OP_INSERT  = 3'd3,
    REG_OP_DELETE  = 3'd4,
    REG_OP_FINISH  = 3'd5
  } reg_idx_t;

  // decoded command
  typedef enum logic [2:0] {
    OPC_COPY    = 3'd0,
    OPC_REPLACE = 3'd1,
    OPC_INSERT  = 3'd2,
    OPC_DELETE  = 3'd3,
    OPC_FINISH  = 3'd4
  } opc_t;

  // item kinds
  localparam logic MODE_PATCH = 1'b0;
  localparam logic MODE_OLD   = 1'b1;

  // error codes
  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_KIND    = 2'd1,
    ERR_OVERRUN = 2'd2,
    ERR_AFTER   = 2'd3
  } err_t;

  // execution phases
  typedef enum logic [3:0] {
    PH_HEADER     = 4'd0,
    PH_OPCODE     = 4'd1,
    PH_COUNT      = 4'd2,
    PH_COPY       = 4'd3,
    PH_REPL_PATCH = 4'd4,
    PH_REPL_OLD   = 4'd5,
    PH_INS_OLD    = 4'd6,
    PH_INS_PATCH  = 4'd7,
    PH_DEL_OLD    = 4'd8,
    PH_FIN_OLD    = 4'd9,
    PH_DONE       = 4'd10
  } phase_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       need_old;
    logic       finished;
    logic [1:0] error;
  } out_item_t;

  // item after classification by the front end
  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
    logic       op_hit;
    opc_t       op;
  } cls_item_t;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

endpackage

### rtl/bpa_front.sv
// front end: opcode registers and item classification
module bpa_front (
  input  logic                 clk,
  input  logic                 rst,
  input  bpa_pkg::cfg_wr_t     cfg,
  input  bpa_pkg::in_item_t    item,
  output bpa_pkg::cls_item_t   cls
);

  logic [7:0] op_copy;
  logic [7:0] op_replace;
  logic [7:0] op_insert;
  logic [7:0] op_delete;
  logic [7:0] op_finish;

  // opcode registers
  always_ff @(posedge clk) begin
    if (rst) begin
      op_copy    <= 8'd0;
      op_replace <= 8'd1;
      op_insert  <= 8'd2;
      op_delete  <= 8'd3;
      op_finish  <= 8'd4;
    end else if (cfg.we) begin
      unique case (cfg.index)
        bpa_pkg::REG_OP_COPY:    op_copy    <= cfg.data[7:0];
        bpa_pkg::REG_OP_REPLACE: op_replace <= cfg.data[7:0];
        bpa_pkg::REG_OP_INSERT:  op_insert  <= cfg.data[7:0];
        bpa_pkg::REG_OP_DELETE:  op_delete  <= cfg.data[7:0];
        bpa_pkg::REG_OP_FINISH:  op_finish  <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

  // priority match of the byte against the opcodes, copy first
  always_comb begin
    cls.mode      = item.mode;
    cls.data_byte = item.data_byte;
    cls.op_hit    = 1'b1;
    if (item.data_byte == op_copy) begin
      cls.op = bpa_pkg::OPC_COPY;
    end else if (item.data_byte == op_replace) begin
      cls.op = bpa_pkg::OPC_REPLACE;
    end else if (item.data_byte == op_insert) begin
      cls.op = bpa_pkg::OPC_INSERT;
    end else if (item.data_byte == op_delete) begin
      cls.op = bpa_pkg::OPC_DELETE;
    end else if (item.data_byte == op_finish) begin
      cls.op = bpa_pkg::OPC_FINISH;
    end else begin
      cls.op     = bpa_pkg::OPC_COPY;
      cls.op_hit = 1'b0;
    end
  end

endmodule

### rtl/bpa_queue.sv
// short queue of classified items between front and back end
`include "binary_patch_applier_core_macros.svh"

module bpa_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  bpa_pkg::cls_item_t push_item,
  input  logic               pop,
  output bpa_pkg::cls_item_t head,
  output logic               full,
  output logic               empty
);

  bpa_pkg::cls_item_t entries [bpa_pkg::QDEPTH];
  logic [bpa_pkg::QPTR_W-1:0] wr_ptr;
  logic [bpa_pkg::QPTR_W-1:0] rd_ptr;
  logic [bpa_pkg::QCNT_W-1:0] fill;

  assign full  = (fill == bpa_pkg::QCNT_W'(bpa_pkg::QDEPTH));
  assign empty = (fill == '0);
  assign head  = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  `BPA_ASSERT_NOW(a_no_overflow, clk, rst, full, !push, "push into full queue")
  `BPA_ASSERT_NOW(a_no_underflow, clk, rst, empty, !pop, "pop from empty queue")
  `BPA_ASSERT_NEXT(a_pop_drains, clk, rst, pop && !push && fill == 1, empty, "queue not drained")

endmodule

### rtl/bpa_exec.sv
// back end: command sequencer, old stream accounting and result register
`include "binary_patch_applier_core_macros.svh"

module bpa_exec (
  input  logic               clk,
  input  logic               rst,
  input  bpa_pkg::cfg_wr_t   cfg,
  input  bpa_pkg::cls_item_t item,
  input  logic               item_avail,
  output logic               pop,
  output logic               res_valid,
  input  logic               res_ready,
  output bpa_pkg::out_item_t res_item
);

  logic [31:0]     old_length;
  bpa_pkg::phase_t phase;
  bpa_pkg::phase_t phase_next;
  logic [3:0]      header_left;
  logic [3:0]      header_left_next;
  bpa_pkg::opc_t   current_op;
  bpa_pkg::opc_t   current_op_next;
  logic [32:0]     count_value;
  logic [32:0]     count_value_next;
  logic [1:0]      count_byte_index;
  logic [1:0]      count_byte_index_next;
  logic [31:0]     old_consumed;
  logic [31:0]     old_consumed_next;

  logic            want_old;
  logic            is_done;
  logic            bad_kind;
  logic            take_ok;
  logic            act;
  logic [32:0]     count_dec;
  logic [31:0]     assembled;
  bpa_pkg::out_item_t result;

  function automatic logic wants_old(bpa_pkg::phase_t ph);
    return ph == bpa_pkg::PH_COPY || ph == bpa_pkg::PH_REPL_OLD ||
           ph == bpa_pkg::PH_INS_OLD || ph == bpa_pkg::PH_DEL_OLD ||
           ph == bpa_pkg::PH_FIN_OLD;
  endfunction

  // a result slot is free when empty or being taken
  assign pop = item_avail && (!res_valid || res_ready);

  // item decode against the current phase
  assign want_old = wants_old(phase);
  assign is_done  = (phase == bpa_pkg::PH_DONE);
  assign bad_kind = (item.mode != want_old);
  assign take_ok  = (old_consumed < old_length);
  assign act      = pop && !is_done && !bad_kind;
  assign count_dec = count_value - 33'(count_value != '0);
  assign assembled = count_value[31:0] |
                     (32'(item.data_byte) << {count_byte_index, 3'b000});

  // old length register
  always_ff @(posedge clk) begin
    if (rst) begin
      old_length <= '0;
    end else if (cfg.we && cfg.index == bpa_pkg::REG_OLD_LENGTH) begin
      old_length <= cfg.data;
    end
  end

  // next state
  always_comb begin
    phase_next            = phase;
    header_left_next      = header_left;
    current_op_next       = current_op;
    count_value_next      = count_value;
    count_byte_index_next = count_byte_index;
    old_consumed_next     = old_consumed;
    if (act && want_old && take_ok) begin
      old_consumed_next = old_consumed + 32'd1;
    end
    if (act) begin
      unique case (phase)
        bpa_pkg::PH_HEADER: begin
          header_left_next = header_left - 4'(header_left != '0);
          if (header_left_next == '0) begin
            phase_next = bpa_pkg::PH_OPCODE;
          end
        end
        bpa_pkg::PH_OPCODE: begin
          if (item.op_hit) begin
            current_op_next = item.op;
            if (item.op == bpa_pkg::OPC_FINISH) begin
              phase_next = take_ok ? bpa_pkg::PH_FIN_OLD : bpa_pkg::PH_DONE;
            end else begin
              phase_next            = bpa_pkg::PH_COUNT;
              count_byte_index_next = '0;
              count_value_next      = '0;
            end
          end
        end
        bpa_pkg::PH_COUNT: begin
          count_value_next = {1'b0, assembled};
          if (count_byte_index != 2'd3) begin
            count_byte_index_next = count_byte_index + 2'd1;
          end else begin
            count_byte_index_next = '0;
            unique case (current_op)
              bpa_pkg::OPC_COPY: begin
                count_value_next = {1'b0, assembled} + 33'd1;
                phase_next       = bpa_pkg::PH_COPY;
              end
              bpa_pkg::OPC_REPLACE: begin
                phase_next = (assembled != '0) ? bpa_pkg::PH_REPL_PATCH
                                               : bpa_pkg::PH_OPCODE;
              end
              bpa_pkg::OPC_INSERT: begin
                count_value_next = {25'd0, assembled[7:0]};
                phase_next       = bpa_pkg::PH_INS_OLD;
              end
              default: begin
                phase_next = (assembled != '0) ? bpa_pkg::PH_DEL_OLD
                                               : bpa_pkg::PH_OPCODE;
              end
            endcase
          end
        end
        bpa_pkg::PH_COPY, bpa_pkg::PH_INS_PATCH, bpa_pkg::PH_DEL_OLD: begin
          count_value_next = count_dec;
          if (count_dec == '0) begin
            phase_next = bpa_pkg::PH_OPCODE;
          end
        end
        bpa_pkg::PH_REPL_PATCH: begin
          phase_next = bpa_pkg::PH_REPL_OLD;
        end
        bpa_pkg::PH_REPL_OLD: begin
          count_value_next = count_dec;
          phase_next = (count_dec != '0) ? bpa_pkg::PH_REPL_PATCH : bpa_pkg::PH_OPCODE;
        end
        bpa_pkg::PH_INS_OLD: begin
          phase_next = (count_value != '0) ? bpa_pkg::PH_INS_PATCH : bpa_pkg::PH_OPCODE;
        end
        bpa_pkg::PH_FIN_OLD: begin
          phase_next = (old_consumed_next >= old_length) ? bpa_pkg::PH_DONE
                                                         : bpa_pkg::PH_FIN_OLD;
        end
        default: begin
          phase_next = bpa_pkg::PH_OPCODE;
        end
      endcase
    end
  end

  // result of the item taken this cycle
  always_comb begin
    result = '0;
    if (is_done) begin
      result.error = bpa_pkg::ERR_AFTER;
    end else if (bad_kind) begin
      result.error = bpa_pkg::ERR_KIND;
    end else if (want_old && !take_ok) begin
      result.error = bpa_pkg::ERR_OVERRUN;
    end else begin
      unique case (phase)
        bpa_pkg::PH_COPY, bpa_pkg::PH_INS_OLD, bpa_pkg::PH_FIN_OLD,
        bpa_pkg::PH_REPL_PATCH, bpa_pkg::PH_INS_PATCH: begin
          result.out_valid = 1'b1;
          result.out_byte  = item.data_byte;
        end
        default: ;
      endcase
    end
    result.finished = (phase_next == bpa_pkg::PH_DONE);
    result.need_old = wants_old(phase_next);
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= (bpa_pkg::HEADER_INIT != '0) ? bpa_pkg::PH_HEADER
                                                       : bpa_pkg::PH_OPCODE;
      header_left      <= bpa_pkg::HEADER_INIT;
      current_op       <= bpa_pkg::OPC_COPY;
      count_value      <= '0;
      count_byte_index <= '0;
      old_consumed     <= '0;
    end else begin
      phase            <= phase_next;
      header_left      <= header_left_next;
      current_op       <= current_op_next;
      count_value      <= count_value_next;
      count_byte_index <= count_byte_index_next;
      old_consumed     <= old_consumed_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= pop || (res_valid && !res_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_item <= result;
    end
  end

  `BPA_ASSERT_NEXT(a_done_sticky, clk, rst, phase == bpa_pkg::PH_DONE, phase == bpa_pkg::PH_DONE, "left finished state")
  `BPA_ASSERT_NOW(a_count_idx, clk, rst, phase != bpa_pkg::PH_COUNT, count_byte_index == '0, "count index outside count phase")
  `BPA_ASSERT_NEXT(a_held_result, clk, rst, res_valid && !res_ready, res_valid && $stable(res_item), "result lost under stall")

endmodule

### rtl/binary_patch_applier_core.sv
// top level of the binary patch applier
//
// channel  direction  handshake              payload
// in       input      in_valid / in_ready    in_item   (mode, data_byte)
// res      output     res_valid / res_ready  res_item  (out_byte .. error)
// cfg      input      cfg_we                 cfg_index, cfg_data
//
// one item per cycle sustained while res_ready is high; each item gives one
// result, held first in the classified item queue and then in the result
// register. the sequencer does all its work on an item as it pops it.
// in_ready falls only when the two-entry queue is full, which happens when
// res_ready is held low; the result register then holds its item.
// rst is synchronous; no clearing pass is needed after it.
module binary_patch_applier_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  bpa_pkg::in_item_t                   in_item,
  output logic                                res_valid,
  input  logic                                res_ready,
  output bpa_pkg::out_item_t                  res_item,
  input  logic                                cfg_we,
  input  logic [bpa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bpa_pkg::CFG_DATA_W-1:0]      cfg_data
);

  bpa_pkg::cfg_wr_t   cfg;
  bpa_pkg::cls_item_t cls;
  bpa_pkg::cls_item_t head;
  logic               q_full;
  logic               q_empty;
  logic               pop;
  logic               push;

  // configuration write bundle
  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  bpa_front u_front (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .item (in_item),
    .cls  (cls)
  );

  bpa_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (cls),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  bpa_exec u_exec (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item       (head),
    .item_avail (!q_empty),
    .pop        (pop),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_item   (res_item)
  );

endmodule

### test/binary_patch_applier_checker.sv
// transfer monitor, byte-merge predictor and result comparison for the patch applier
module binary_patch_applier_checker import bpa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_item_t              in_item,
  input  logic                  res_valid,
  input  logic                  res_ready,
  input  out_item_t             res_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int unsigned           fail_count,
  output int unsigned           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow registers
  logic [31:0] old_length_r;
  logic [7:0]  code_copy, code_replace, code_insert, code_delete, code_finish;

  // shadow sequencer state
  phase_t      phase;
  logic [3:0]  hdr_left;
  opc_t        cur_op;
  logic [32:0] count;
  logic [1:0]  cnt_idx;
  logic [31:0] old_used;

  out_item_t   want_q [$];
  out_item_t   want;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report(string what, int unsigned got, int unsigned wanted);
    fail_count++;
    $display("%0t mismatch: %s got %0h wanted %0h", $time, what, got, wanted);
  endtask

  function automatic void reset_shadow();
    old_length_r = '0;
    code_copy    = 8'd0;
    code_replace = 8'd1;
    code_insert  = 8'd2;
    code_delete  = 8'd3;
    code_finish  = 8'd4;
    hdr_left     = HEADER_INIT;
    phase        = (hdr_left != 0) ? PH_HEADER : PH_OPCODE;
    cur_op       = OPC_COPY;
    count        = '0;
    cnt_idx      = '0;
    old_used     = '0;
  endfunction

  function automatic void write_shadow(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    case (reg_idx_t'(idx))
      REG_OLD_LENGTH: old_length_r = v;
      REG_OP_COPY:    code_copy    = v[7:0];
      REG_OP_REPLACE: code_replace = v[7:0];
      REG_OP_INSERT:  code_insert  = v[7:0];
      REG_OP_DELETE:  code_delete  = v[7:0];
      REG_OP_FINISH:  code_finish  = v[7:0];
      default: ;
    endcase
  endfunction

  function automatic logic wants_old_byte(phase_t ph);
    return ph inside {PH_COPY, PH_REPL_OLD, PH_INS_OLD, PH_DEL_OLD, PH_FIN_OLD};
  endfunction

  // one old byte used up, unless the old stream is already exhausted
  function automatic logic take_old();
    if (old_used >= old_length_r) return 1'b0;
    old_used++;
    return 1'b1;
  endfunction

  function automatic void enter_finish();
    phase = (old_used >= old_length_r) ? PH_DONE : PH_FIN_OLD;
  endfunction

  // advance the shadow state by one item and return the new-file result
  function automatic out_item_t merge_step(in_item_t it);
    out_item_t r;
    err_t      err;
    logic      hit;
    r   = '0;
    err = ERR_NONE;
    hit = 1'b1;
    if (phase == PH_DONE) begin
      err = ERR_AFTER;
    end else if (it.mode != wants_old_byte(phase)) begin
      err = ERR_KIND;
    end else begin
      case (phase)
        PH_HEADER: begin
          if (hdr_left != 0) hdr_left--;
          if (hdr_left == 0) phase = PH_OPCODE;
        end
        PH_OPCODE: begin
          // shared codes resolve in command order
          if (it.data_byte == code_copy) cur_op = OPC_COPY;
          else if (it.data_byte == code_replace) cur_op = OPC_REPLACE;
          else if (it.data_byte == code_insert) cur_op = OPC_INSERT;
          else if (it.data_byte == code_delete) cur_op = OPC_DELETE;
          else if (it.data_byte == code_finish) cur_op = OPC_FINISH;
          else hit = 1'b0;
          if (hit) begin
            if (cur_op == OPC_FINISH) begin
              enter_finish();
            end else begin
              phase   = PH_COUNT;
              cnt_idx = '0;
              count   = '0;
            end
          end
        end
        PH_COUNT: begin
          // little-endian count bytes
          count     = count | (33'(it.data_byte) << (8 * cnt_idx));
          count[32] = 1'b0;
          if (cnt_idx < 2'd3) begin
            cnt_idx++;
          end else begin
            cnt_idx = '0;
            case (cur_op)
              OPC_COPY: begin
                count = count + 33'd1;
                phase = PH_COPY;
              end
              OPC_REPLACE: phase = (count != 0) ? PH_REPL_PATCH : PH_OPCODE;
              OPC_INSERT: begin
                count = count & 33'hFF;
                phase = PH_INS_OLD;
              end
              default: phase = (count != 0) ? PH_DEL_OLD : PH_OPCODE;
            endcase
          end
        end
        PH_COPY: begin
          if (take_old()) begin
            r.out_byte  = it.data_byte;
            r.out_valid = 1'b1;
          end else begin
            err = ERR_OVERRUN;
          end
          if (count != 0) count--;
          if (count == 0) phase = PH_OPCODE;
        end
        PH_REPL_PATCH: begin
          r.out_byte  = it.data_byte;
          r.out_valid = 1'b1;
          phase       = PH_REPL_OLD;
        end
        PH_REPL_OLD: begin
          if (!take_old()) err = ERR_OVERRUN;
          if (count != 0) count--;
          phase = (count != 0) ? PH_REPL_PATCH : PH_OPCODE;
        end
        PH_INS_OLD: begin
          if (take_old()) begin
            r.out_byte  = it.data_byte;
            r.out_valid = 1'b1;
          end else begin
            err = ERR_OVERRUN;
          end
          phase = (count != 0) ? PH_INS_PATCH : PH_OPCODE;
        end
        PH_INS_PATCH: begin
          r.out_byte  = it.data_byte;
          r.out_valid = 1'b1;
          if (count != 0) count--;
          if (count == 0) phase = PH_OPCODE;
        end
        PH_DEL_OLD: begin
          if (!take_old()) err = ERR_OVERRUN;
          if (count != 0) count--;
          if (count == 0) phase = PH_OPCODE;
        end
        PH_FIN_OLD: begin
          if (take_old()) begin
            r.out_byte  = it.data_byte;
            r.out_valid = 1'b1;
          end else begin
            err = ERR_OVERRUN;
          end
          enter_finish();
        end
        default: phase = PH_OPCODE;
      endcase
    end
    r.need_old = (phase != PH_DONE) && wants_old_byte(phase);
    r.finished = (phase == PH_DONE);
    r.error    = err;
    return r;
  endfunction

  // predict on input transfers, compare on result transfers
  always @(posedge clk) begin
    if (rst) begin
      reset_shadow();
      want_q.delete();
    end else begin
      if (in_valid && in_ready) want_q.push_back(merge_step(in_item));
      if (res_valid && res_ready) begin
        if (want_q.size() == 0) begin
          report("result with nothing outstanding", 32'(res_item), 32'd0);
        end else begin
          want = want_q.pop_front();
          if (res_item.out_byte !== want.out_byte)
            report("out_byte", 32'(res_item.out_byte), 32'(want.out_byte));
          if (res_item.out_valid !== want.out_valid)
            report("out_valid", 32'(res_item.out_valid), 32'(want.out_valid));
          if (res_item.need_old !== want.need_old)
            report("need_old", 32'(res_item.need_old), 32'(want.need_old));
          if (res_item.finished !== want.finished)
            report("finished", 32'(res_item.finished), 32'(want.finished));
          if (res_item.error !== want.error)
            report("error", 32'(res_item.error), 32'(want.error));
        end
      end
      if (cfg_we) write_shadow(cfg_index, cfg_data);
    end
    pending = want_q.size();
  end

endmodule

### test/binary_patch_applier_core_tb.sv
// stimulus and verdict for the binary patch applier core
module binary_patch_applier_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bpa_pkg::*;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_item;
  logic                  res_valid;
  logic                  res_ready;
  out_item_t             res_item;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int unsigned           fail_count;
  int unsigned           pending;

  // generator view of the configuration and of old bytes used so far
  logic [31:0]           g_len;
  logic [4:0][7:0]       g_code;
  logic [31:0]           g_used;
  int unsigned           phase_items;
  logic                  noise_on;
  int unsigned           cyc = 0;

  binary_patch_applier_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  binary_patch_applier_checker i_monitor (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_item   (res_item),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    #200000;
    $display("tb: failure");
    $finish;
  end

  always @(posedge clk) cyc <= cyc + 1;

  // random idle cycle, with a calm window in the middle of the run
  function automatic logic idle_roll();
    return (cyc < 600 || cyc > 1000) && ($urandom_range(99) < 11);
  endfunction

  // result side back-pressure
  initial begin
    res_ready = 1'b0;
    forever begin
      @(negedge clk);
      res_ready <= !idle_roll();
    end
  end

  // one input transfer, called and returning at a falling edge
  task automatic send_byte(logic kind, logic [7:0] b);
    while (idle_roll()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{mode: kind, data_byte: b};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // in-sequence item, sometimes preceded by an item of the wrong kind
  task automatic emit(logic kind, logic [7:0] b);
    if (noise_on && $urandom_range(99) < 4) send_byte(!kind, 8'($urandom));
    send_byte(kind, b);
    phase_items++;
    if (kind == MODE_OLD && g_used < g_len) g_used++;
  endtask

  task automatic send_count(logic [31:0] c);
    for (int i = 0; i < 4; i++) emit(MODE_PATCH, c[8*i +: 8]);
  endtask

  // wait until every result is back and the pipeline is empty
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(negedge clk);
  endtask

  task automatic set_config(logic [31:0] len, logic [4:0][7:0] codes);
    settle();
    write_reg(REG_OLD_LENGTH, len);
    write_reg(REG_OP_COPY,    {24'($urandom), codes[OPC_COPY]});
    write_reg(REG_OP_REPLACE, {24'($urandom), codes[OPC_REPLACE]});
    write_reg(REG_OP_INSERT,  {24'($urandom), codes[OPC_INSERT]});
    write_reg(REG_OP_DELETE,  {24'($urandom), codes[OPC_DELETE]});
    write_reg(REG_OP_FINISH,  {24'($urandom), codes[OPC_FINISH]});
    cfg_we <= 1'b0;
    g_len  = len;
    g_code = codes;
  endtask

  function automatic logic [4:0][7:0] distinct_codes();
    logic [4:0][7:0] r;
    logic            clash;
    for (int i = 0; i < 5; i++) begin
      do begin
        r[i]  = 8'($urandom);
        clash = 1'b0;
        for (int j = 0; j < i; j++) if (r[j] == r[i]) clash = 1'b1;
      end while (clash);
    end
    return r;
  endfunction

  // opcode lookup with the block's priority order
  function automatic void decode(input logic [7:0] b, output opc_t op, output logic hit);
    hit = 1'b1;
    op  = OPC_COPY;
    if (b == g_code[OPC_COPY]) op = OPC_COPY;
    else if (b == g_code[OPC_REPLACE]) op = OPC_REPLACE;
    else if (b == g_code[OPC_INSERT]) op = OPC_INSERT;
    else if (b == g_code[OPC_DELETE]) op = OPC_DELETE;
    else if (b == g_code[OPC_FINISH]) op = OPC_FINISH;
    else hit = 1'b0;
  endfunction

  // one well-formed command with random content, or a stray opcode byte
  task automatic run_command();
    logic [7:0]  code;
    opc_t        op;
    logic        hit;
    logic [31:0] c;
    if ($urandom_range(99) < 8) begin
      do begin
        code = 8'($urandom);
        decode(code, op, hit);
      end while (hit && op == OPC_FINISH);
    end else begin
      op   = opc_t'($urandom_range(0, 3));
      code = g_code[op];
      decode(code, op, hit);
    end
    emit(MODE_PATCH, code);
    if (!hit) return;
    case (op)
      OPC_COPY: begin
        c = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        send_count(c);
        repeat (c + 1) emit(MODE_OLD, 8'($urandom));
      end
      OPC_REPLACE: begin
        c = $urandom_range(0, 8);
        send_count(c);
        repeat (c) begin
          emit(MODE_PATCH, 8'($urandom));
          emit(MODE_OLD, 8'($urandom));
        end
      end
      OPC_INSERT: begin
        // only the low count byte matters, the rest is random
        c      = $urandom;
        c[7:0] = ($urandom_range(19) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
        send_count(c);
        emit(MODE_OLD, 8'($urandom));
        repeat (c[7:0]) emit(MODE_PATCH, 8'($urandom));
      end
      default: begin
        c = $urandom_range(0, 12);
        send_count(c);
        repeat (c) emit(MODE_OLD, 8'($urandom));
      end
    endcase
  endtask

  task automatic run_phase(int unsigned n);
    phase_items = 0;
    while (phase_items < n) run_command();
  endtask

  // stimulus
  initial begin
    int unsigned k;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    g_used    = '0;
    noise_on  = 1'b0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // directed: header, stray opcode, copy, replace, insert and delete with edge counts
    set_config(32'hFFFF_FFFF, {8'd4, 8'd3, 8'd2, 8'd1, 8'd0});
    send_byte(MODE_OLD, 8'h5A);
    emit(MODE_PATCH, 8'h00);
    emit(MODE_PATCH, 8'hFF);
    repeat (HEADER_BYTES - 2) emit(MODE_PATCH, 8'($urandom));
    emit(MODE_PATCH, 8'hFF);
    emit(MODE_PATCH, g_code[OPC_COPY]);
    send_count(32'd0);
    emit(MODE_OLD, 8'hFF);
    emit(MODE_PATCH, g_code[OPC_REPLACE]);
    send_count(32'd0);
    emit(MODE_PATCH, g_code[OPC_INSERT]);
    send_count(32'hFFFF_FF01);
    emit(MODE_OLD, 8'h00);
    emit(MODE_PATCH, 8'h80);
    emit(MODE_PATCH, g_code[OPC_DELETE]);
    send_count(32'd0);

    // random phases over several register settings
    noise_on = 1'b1;
    run_phase(230);
    set_config(32'hFFFF_FFFF, {8'h7F, 8'h80, 8'h00, 8'hFE, 8'hFF});
    run_phase(230);
    set_config(g_used + 32'd20, distinct_codes());
    run_phase(230);
    set_config(32'd0, {8'($urandom_range(3)), 8'($urandom_range(3)), 8'($urandom_range(3)),
                       8'($urandom_range(3)), 8'($urandom_range(3))});
    run_phase(230);
    set_config($urandom, {8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                          8'($urandom)});
    run_phase(230);
    set_config(32'hFFFF_FFFF, distinct_codes());
    run_phase(230);

    // finish, either at once or after a few more old bytes
    k = $urandom_range(0, 4);
    set_config(g_used + k, distinct_codes());
    emit(MODE_PATCH, g_code[OPC_FINISH]);
    if (k != 0) begin
      repeat (k - 1) emit(MODE_OLD, 8'($urandom));
      if ($urandom_range(1) == 1) begin
        // shrink the old stream so the last byte overruns
        settle();
        write_reg(REG_OLD_LENGTH, g_used);
        cfg_we <= 1'b0;
        g_len = g_used;
      end
      emit(MODE_OLD, 8'($urandom));
    end

    // items after the end
    repeat (6) send_byte(1'($urandom_range(1)), 8'($urandom));
    in_valid <= 1'b0;

    // drain
    for (int w = 0; w < 5000 && pending != 0; w++) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
